/* design/bsfr_pkg.sv */
// Package for the byte-stuffed frame receiver.
// Holds the store size, register indexes and reset values, controller states and the
// command and status structs that pass between the controller and the datapath.
package bsfr_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 2);
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE     = CFG_IDX_W'(3);

    localparam logic       RST_CHECKSUM_ENABLE = 1'b1;
    localparam logic [7:0] RST_START_CODE      = 8'd1;
    localparam logic [7:0] RST_END_CODE        = 8'd4;
    localparam logic [7:0] RST_ESCAPE_CODE     = 8'd27;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_data;
        logic load_empty;
    } t_cmd;

    typedef struct packed {
        logic close_ok;
        logic pay_zero;
        logic rd_last;
        logic out_free;
    } t_status;

endpackage

/* design/bsfr_ctrl.sv */
// Controller state machine of the byte-stuffed frame receiver.
// Takes input beats and sequences the read-out of a good frame.
// Depends on bsfr_pkg.
module bsfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bsfr_pkg::t_status i_status,
    output bsfr_pkg::t_cmd   o_cmd
);

    bsfr_pkg::t_state r_state;
    bsfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsfr_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.close_ok) begin
                    n_state = i_status.pay_zero ? bsfr_pkg::ST_EMPTY : bsfr_pkg::ST_READ;
                end
            end
            bsfr_pkg::ST_READ: begin
                n_state = bsfr_pkg::ST_LOAD;
            end
            bsfr_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.rd_last ? bsfr_pkg::ST_IDLE : bsfr_pkg::ST_READ;
                end
            end
            bsfr_pkg::ST_EMPTY: begin
                if (i_status.out_free) begin
                    n_state = bsfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            bsfr_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            bsfr_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            bsfr_pkg::ST_LOAD: begin
                o_cmd.load_data = i_status.out_free;
            end
            bsfr_pkg::ST_EMPTY: begin
                o_cmd.load_empty = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* design/bsfr_dpath.sv */
// Datapath of the byte-stuffed frame receiver: configuration registers,
// byte classification, frame store, length, running sum and output register.
// Depends on bsfr_pkg.
module bsfr_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_out_stall,
    input  bsfr_pkg::t_cmd                   i_cmd,
    output bsfr_pkg::t_status                o_status,
    output logic                             o_out_valid,
    output logic [7:0]                       o_data_byte,
    output logic                             o_frame_last,
    output logic                             o_frame_empty
);

    logic                         r_checksum_enable;
    logic [7:0]                   r_start_code;
    logic [7:0]                   r_end_code;
    logic [7:0]                   r_escape_code;

    logic                         r_escape_pending;
    logic                         r_in_frame;
    logic [bsfr_pkg::LEN_W-1:0]   r_len;
    logic [7:0]                   r_sum;
    logic [7:0]                   r_last_byte;
    logic [bsfr_pkg::LEN_W-1:0]   r_pay;
    logic [bsfr_pkg::LEN_W-1:0]   r_rd_ptr;
    logic [7:0]                   r_rd_data;
    logic [7:0]                   r_store [bsfr_pkg::FRAME_BYTES];

    logic                         r_out_valid;
    logic [7:0]                   r_out_data;
    logic                         r_out_last;
    logic                         r_out_empty;

    logic                         is_start;
    logic                         is_escape;
    logic                         is_end;
    logic                         is_data;
    logic                         has_room;
    logic                         wr_en;
    logic                         sum_ok;
    logic                         frame_good;
    logic [bsfr_pkg::LEN_W-1:0]   pay_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum_enable <= bsfr_pkg::RST_CHECKSUM_ENABLE;
            r_start_code      <= bsfr_pkg::RST_START_CODE;
            r_end_code        <= bsfr_pkg::RST_END_CODE;
            r_escape_code     <= bsfr_pkg::RST_ESCAPE_CODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsfr_pkg::REG_CHECKSUM_ENABLE: r_checksum_enable <= i_cfg_data[0];
                bsfr_pkg::REG_START_CODE:      r_start_code      <= i_cfg_data;
                bsfr_pkg::REG_END_CODE:        r_end_code        <= i_cfg_data;
                bsfr_pkg::REG_ESCAPE_CODE:     r_escape_code     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign is_start  = !r_escape_pending && (i_rx_byte == r_start_code);
    assign is_escape = !r_escape_pending && !is_start && (i_rx_byte == r_escape_code);
    assign is_end    = !r_escape_pending && !is_start && !is_escape
                       && (i_rx_byte == r_end_code);
    assign is_data   = !is_start && !is_escape && !is_end;
    assign has_room  = r_len < bsfr_pkg::LEN_W'(bsfr_pkg::FRAME_BYTES);
    assign wr_en     = i_cmd.accept && is_data && has_room;

    assign sum_ok     = (r_sum - r_last_byte) == r_last_byte;
    assign frame_good = (r_len <= bsfr_pkg::LEN_W'(bsfr_pkg::FRAME_BYTES))
                        && (!r_checksum_enable
                            || ((r_len != '0) && sum_ok));
    assign pay_len    = r_checksum_enable ? r_len - bsfr_pkg::LEN_W'(1) : r_len;

    assign o_status.close_ok = is_end && r_in_frame && frame_good;
    assign o_status.pay_zero = pay_len == '0;
    assign o_status.rd_last  = r_rd_ptr == r_pay;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending <= 1'b0;
            r_in_frame       <= 1'b0;
            r_len            <= '0;
            r_sum            <= '0;
        end else if (i_cmd.accept) begin
            if (is_start) begin
                r_in_frame <= 1'b1;
                r_len      <= '0;
                r_sum      <= '0;
            end else if (is_escape) begin
                r_escape_pending <= 1'b1;
            end else if (is_end) begin
                if (r_in_frame) begin
                    r_in_frame <= 1'b0;
                    r_len      <= '0;
                    r_sum      <= '0;
                end
            end else begin
                r_escape_pending <= 1'b0;
                if (has_room) begin
                    r_len <= r_len + bsfr_pkg::LEN_W'(1);
                    r_sum <= r_sum + i_rx_byte;
                end else begin
                    r_len <= bsfr_pkg::LEN_W'(bsfr_pkg::FRAME_BYTES + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_last_byte <= i_rx_byte;
        end
        if (i_cmd.accept && is_end) begin
            r_pay    <= pay_len;
            r_rd_ptr <= '0;
        end else if (i_cmd.rd_issue) begin
            r_rd_ptr <= r_rd_ptr + bsfr_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_len[bsfr_pkg::ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_store[r_rd_ptr[bsfr_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_data || i_cmd.load_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_out_data  <= r_rd_data;
            r_out_last  <= o_status.rd_last;
            r_out_empty <= 1'b0;
        end else if (i_cmd.load_empty) begin
            r_out_data  <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_byte   = r_out_data;
    assign o_frame_last  = r_out_last;
    assign o_frame_empty = r_out_empty;

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= bsfr_pkg::LEN_W'(bsfr_pkg::FRAME_BYTES + 1))
        else $error("Frame length beyond its saturation value.");

    a_rd_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> r_rd_ptr < r_pay)
        else $error("Store read past the payload of the frame.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_data || i_cmd.load_empty) |-> o_status.out_free)
        else $error("Output register overwritten before its beat was taken.");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_last && (r_out_data == '0)))
        else $error("Empty-frame beat without last mark or with data.");

endmodule

/* design/byte_stuffed_frame_receiver_core.sv */
// Byte-stuffed frame receiver: takes one raw link byte per input beat and
// delivers the payload of each good frame as a burst of output beats. While
// no frame is being delivered, an input beat is taken in every cycle. A good
// end code holds the input stalled while its frame is read back from the
// single-port frame store: each payload byte takes a registered store read,
// then the load of the output register; an empty frame only loads an
// empty-frame beat. A load waits on an output stall. The store needs no
// clearing pass after reset. Depends on bsfr_pkg, bsfr_ctrl and bsfr_dpath.
module byte_stuffed_frame_receiver_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_data_byte,
    output logic                           o_frame_last,
    output logic                           o_frame_empty,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    bsfr_pkg::t_cmd    cmd;
    bsfr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bsfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bsfr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_rx_byte),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_data_byte   (o_data_byte),
        .o_frame_last  (o_frame_last),
        .o_frame_empty (o_frame_empty)
    );

endmodule
